FILE: rtl/dqpb_pkg.sv
package dqpb_pkg;

    localparam int NAME_LIMIT   = 255;
    localparam int STORE_DEPTH  = 256;

    // Encoded name store: one leading length byte ahead of the stored characters.
    localparam int ENC_DEPTH    = STORE_DEPTH + 1;
    localparam int ENC_AW       = $clog2(ENC_DEPTH);
    localparam int POS_W        = $clog2(STORE_DEPTH + 2);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

    localparam int MSG_W        = 9;
    localparam int ENC_W        = 10;
    localparam int HEADER_BYTES = 12;
    localparam int TAIL_BYTES   = 4;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_BSL = 8'h5C;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [8:0] COUNT_SAT = 9'd511;

    typedef struct packed {
        logic             error;
        logic [15:0]      query_id;
        logic             rd;
        logic [15:0]      query_type;
        logic [15:0]      query_class;
        logic [MSG_W-1:0] name_len;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [ENC_AW-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

endpackage

FILE: rtl/dqpb_front.sv
module dqpb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_name_char,
    input  logic                 i_final_char,
    input  logic [15:0]          i_query_id,
    input  logic                 i_recursion_desired,
    input  logic [15:0]          i_query_type,
    input  logic [15:0]          i_query_class,
    output dqpb_pkg::t_store_wr  o_store_wr,
    output logic                 o_job_push,
    output dqpb_pkg::t_job       o_job,
    input  logic                 i_job_full,
    input  logic                 i_store_release
);
    import dqpb_pkg::*;

    typedef enum logic {S_LOAD, S_CLOSE} t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [8:0]        r_counted, n_counted;
    logic              r_ovf, n_ovf;
    logic              r_last_dot, n_last_dot;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ENC_AW-1:0] r_lstart, n_lstart;
    logic [7:0]        r_lab, n_lab;
    logic              r_busy, n_busy;
    logic [15:0]       r_qid, n_qid;
    logic              r_rd, n_rd;
    logic [15:0]       r_qtype, n_qtype;
    logic [15:0]       r_qclass, n_qclass;

    logic              accept;
    logic              is_dot;
    logic              is_bsl;
    logic              root;
    logic              err;
    logic [ENC_W-1:0]  enc_len;
    logic [MSG_W-1:0]  name_len;

    assign o_stall = (r_state != S_LOAD) || r_busy;
    assign accept  = i_valid && !o_stall;
    assign is_dot  = (i_name_char == CHAR_DOT);
    assign is_bsl  = (i_name_char == CHAR_BSL);

    assign root    = (r_n == '0) || ((r_n == CNT_W'(1)) && r_last_dot);
    assign enc_len = ENC_W'(r_counted) + ENC_W'(1)
                   + (((r_n == '0) || !r_last_dot) ? ENC_W'(1) : ENC_W'(0));
    assign err     = r_ovf || (enc_len > ENC_W'(NAME_LIMIT));
    assign name_len = root       ? '0 :
                      r_last_dot ? MSG_W'(r_lstart) : MSG_W'(r_pos);

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_counted  = r_counted;
        n_ovf      = r_ovf;
        n_last_dot = r_last_dot;
        n_pos      = r_pos;
        n_lstart   = r_lstart;
        n_lab      = r_lab;
        n_busy     = r_busy;
        n_qid      = r_qid;
        n_rd       = r_rd;
        n_qtype    = r_qtype;
        n_qclass   = r_qclass;
        o_store_wr = '0;
        o_job_push = 1'b0;

        o_job.error       = err;
        o_job.query_id    = r_qid;
        o_job.rd          = r_rd;
        o_job.query_type  = r_qtype;
        o_job.query_class = r_qclass;
        o_job.name_len    = name_len;

        if (i_store_release) begin
            n_busy = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (i_name_char != CHAR_NUL) begin
                        if (r_n < CNT_W'(STORE_DEPTH)) begin
                            n_n        = r_n + 1'b1;
                            n_last_dot = is_dot;
                            if (is_dot) begin
                                // patch the open label's length, open a new one
                                o_store_wr.en   = 1'b1;
                                o_store_wr.addr = r_lstart;
                                o_store_wr.data = r_lab;
                                n_lstart        = r_pos[ENC_AW-1:0];
                                n_pos           = r_pos + 1'b1;
                                n_lab           = '0;
                            end else if (!is_bsl) begin
                                o_store_wr.en   = 1'b1;
                                o_store_wr.addr = r_pos[ENC_AW-1:0];
                                o_store_wr.data = i_name_char;
                                n_pos           = r_pos + 1'b1;
                                n_lab           = r_lab + 1'b1;
                            end
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (!is_bsl && (r_counted != COUNT_SAT)) begin
                            n_counted = r_counted + 1'b1;
                        end
                    end
                    if (i_final_char) begin
                        n_qid    = i_query_id;
                        n_rd     = i_recursion_desired;
                        n_qtype  = i_query_type;
                        n_qclass = i_query_class;
                        n_state  = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    // close the trailing label when the name has no final dot
                    if (!root && !r_last_dot && !err) begin
                        o_store_wr.en   = 1'b1;
                        o_store_wr.addr = r_lstart;
                        o_store_wr.data = r_lab;
                    end
                    n_busy     = !err;
                    n_n        = '0;
                    n_counted  = '0;
                    n_ovf      = 1'b0;
                    n_last_dot = 1'b0;
                    n_pos      = POS_W'(1);
                    n_lstart   = '0;
                    n_lab      = '0;
                    n_state    = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_n        <= '0;
            r_counted  <= '0;
            r_ovf      <= 1'b0;
            r_last_dot <= 1'b0;
            r_pos      <= POS_W'(1);
            r_lstart   <= '0;
            r_lab      <= '0;
            r_busy     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_n        <= n_n;
            r_counted  <= n_counted;
            r_ovf      <= n_ovf;
            r_last_dot <= n_last_dot;
            r_pos      <= n_pos;
            r_lstart   <= n_lstart;
            r_lab      <= n_lab;
            r_busy     <= n_busy;
        end
        r_qid    <= n_qid;
        r_rd     <= n_rd;
        r_qtype  <= n_qtype;
        r_qclass <= n_qclass;
    end

endmodule

FILE: rtl/dqpb_job_fifo.sv
module dqpb_job_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dqpb_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dqpb_pkg::t_job  o_job
);
    import dqpb_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/dqpb_back.sv
module dqpb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dqpb_pkg::t_store_wr  i_store_wr,
    input  logic                 i_job_valid,
    input  dqpb_pkg::t_job       i_job,
    output logic                 o_job_pop,
    output logic                 o_store_release,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_packet_word,
    output logic [3:0]           o_bytes_valid,
    output logic                 o_last_word,
    output logic [8:0]           o_message_length,
    output logic                 o_name_error
);
    import dqpb_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    logic [7:0]        r_mem [ENC_DEPTH];
    logic [7:0]        r_rd_data;
    logic [ENC_AW-1:0] rd_addr;
    logic [MSG_W-1:0]  rd_diff;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [MSG_W-1:0]  r_pos, n_pos;
    logic [MSG_W-1:0]  r_name_end, n_name_end;
    logic [MSG_W-1:0]  r_msg_last, n_msg_last;
    logic [63:0]       r_acc, n_acc;
    logic [2:0]        r_cnt, n_cnt;

    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_out_word, n_out_word;
    logic [3:0]        r_out_bytes, n_out_bytes;
    logic              r_out_last, n_out_last;
    logic [8:0]        r_out_len, n_out_len;
    logic              r_out_err, n_out_err;

    logic              out_free;
    logic              last_byte;
    logic [MSG_W-1:0]  tail_d;
    logic [7:0]        cur_byte;
    logic [63:0]       ins_word;

    assign out_free  = !r_out_valid || !i_stall;
    assign last_byte = (r_pos == r_msg_last);
    assign tail_d    = r_pos - r_name_end;

    always_comb begin
        cur_byte = 8'h00;
        if (r_pos < MSG_W'(HEADER_BYTES)) begin
            case (r_pos[3:0])
                4'd0:    cur_byte = r_job.query_id[15:8];
                4'd1:    cur_byte = r_job.query_id[7:0];
                4'd2:    cur_byte = {7'b0, r_job.rd};
                4'd5:    cur_byte = 8'h01;
                default: cur_byte = 8'h00;
            endcase
        end else if (r_pos < r_name_end) begin
            cur_byte = r_rd_data;
        end else begin
            case (tail_d[2:0])
                3'd1:    cur_byte = r_job.query_type[15:8];
                3'd2:    cur_byte = r_job.query_type[7:0];
                3'd3:    cur_byte = r_job.query_class[15:8];
                3'd4:    cur_byte = r_job.query_class[7:0];
                default: cur_byte = 8'h00;
            endcase
        end
    end

    always_comb begin
        ins_word = r_acc;
        for (int b = 0; b < 8; b++) begin
            if (r_cnt == 3'(b)) begin
                ins_word[63-8*b -: 8] = cur_byte;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_job           = r_job;
        n_pos           = r_pos;
        n_name_end      = r_name_end;
        n_msg_last      = r_msg_last;
        n_acc           = r_acc;
        n_cnt           = r_cnt;
        n_out_valid     = r_out_valid && i_stall;
        n_out_word      = r_out_word;
        n_out_bytes     = r_out_bytes;
        n_out_last      = r_out_last;
        n_out_len       = r_out_len;
        n_out_err       = r_out_err;
        o_job_pop       = 1'b0;
        o_store_release = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid && out_free) begin
                    o_job_pop = 1'b1;
                    if (i_job.error) begin
                        n_out_valid = 1'b1;
                        n_out_word  = '0;
                        n_out_bytes = '0;
                        n_out_last  = 1'b1;
                        n_out_len   = '0;
                        n_out_err   = 1'b1;
                    end else begin
                        n_job      = i_job;
                        n_pos      = '0;
                        n_acc      = '0;
                        n_cnt      = '0;
                        n_name_end = i_job.name_len + MSG_W'(HEADER_BYTES);
                        n_msg_last = i_job.name_len + MSG_W'(HEADER_BYTES + TAIL_BYTES);
                        n_state    = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_pos = r_pos + 1'b1;
                    if ((r_cnt == 3'd7) || last_byte) begin
                        n_out_valid = 1'b1;
                        n_out_word  = ins_word;
                        n_out_bytes = {1'b0, r_cnt} + 4'd1;
                        n_out_last  = last_byte;
                        n_out_len   = last_byte ? (r_msg_last + 9'd1) : '0;
                        n_out_err   = 1'b0;
                        n_acc       = '0;
                        n_cnt       = '0;
                    end else begin
                        n_acc = ins_word;
                        n_cnt = r_cnt + 3'd1;
                    end
                    if (last_byte) begin
                        o_store_release = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read one byte ahead so the registered data lines up with r_pos
    assign rd_diff = n_pos - MSG_W'(HEADER_BYTES);
    assign rd_addr = ENC_AW'(rd_diff);

    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_mem[i_store_wr.addr] <= i_store_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_job       <= n_job;
        r_pos       <= n_pos;
        r_name_end  <= n_name_end;
        r_msg_last  <= n_msg_last;
        r_acc       <= n_acc;
        r_cnt       <= n_cnt;
        r_out_word  <= n_out_word;
        r_out_bytes <= n_out_bytes;
        r_out_last  <= n_out_last;
        r_out_len   <= n_out_len;
        r_out_err   <= n_out_err;
    end

    assign o_valid          = r_out_valid;
    assign o_packet_word    = r_out_word;
    assign o_bytes_valid    = r_out_bytes;
    assign o_last_word      = r_out_last;
    assign o_message_length = r_out_len;
    assign o_name_error     = r_out_err;

endmodule

FILE: rtl/dns_query_packet_builder.sv
// DNS query message builder.
// Input channel (i_valid / o_stall): one name character per word, one word
// per cycle while loading. The word with i_final_char set also carries the
// query id, RD bit, type and class; zero characters are skipped but their
// final flag still acts.
// Output channel (o_valid / i_stall): 64-bit message words, first byte in
// bits 63:56, with byte count, last-word flag, total length on the last word
// and an error flag on the lone word that replaces a name too long or one
// that overran the character store.
// After the final character, the close state closes the name and queues a
// job; the back end then walks the message one byte per cycle while the
// output is not stalled.
// Input is stalled from the final character until the back end has packed
// the last message byte; an error word leaves the store free at once.
// When the receiver stalls, the output register holds its word and the byte
// walker pauses; the job queue lets the front close the next name meanwhile.
// Reset clears front counters, queue and valid flags, not the store contents.
module dns_query_packet_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_name_char,
    input  logic        i_final_char,
    input  logic [15:0] i_query_id,
    input  logic        i_recursion_desired,
    input  logic [15:0] i_query_type,
    input  logic [15:0] i_query_class,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_packet_word,
    output logic [3:0]  o_bytes_valid,
    output logic        o_last_word,
    output logic [8:0]  o_message_length,
    output logic        o_name_error
);
    import dqpb_pkg::*;

    t_store_wr store_wr;
    t_job      push_job;
    t_job      pop_job;
    logic      job_push;
    logic      job_full;
    logic      job_valid;
    logic      job_pop;
    logic      store_release;

    // front: load characters and pre-encode labels into the store
    dqpb_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_name_char         (i_name_char),
        .i_final_char        (i_final_char),
        .i_query_id          (i_query_id),
        .i_recursion_desired (i_recursion_desired),
        .i_query_type        (i_query_type),
        .i_query_class       (i_query_class),
        .o_store_wr          (store_wr),
        .o_job_push          (job_push),
        .o_job               (push_job),
        .i_job_full          (job_full),
        .i_store_release     (store_release)
    );

    // hold closed names until the back end takes them
    dqpb_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (push_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (pop_job)
    );

    // back: walk header, stored name and tail, pack bytes into words
    dqpb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_store_wr       (store_wr),
        .i_job_valid      (job_valid),
        .i_job            (pop_job),
        .o_job_pop        (job_pop),
        .o_store_release  (store_release),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packet_word    (o_packet_word),
        .o_bytes_valid    (o_bytes_valid),
        .o_last_word      (o_last_word),
        .o_message_length (o_message_length),
        .o_name_error     (o_name_error)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dqpb_pkg::*;

    // Largest message buffer the encoder can touch, guard bytes included.
    localparam int MSG_MAX    = HEADER_BYTES + NAME_LIMIT + TAIL_BYTES + 8;
    // The bench adds no random idling on either side inside this window of cycles.
    localparam int QUIET_FROM = 2000;
    localparam int QUIET_TO   = 5000;
    localparam int IDLE_PCT   = 9;
    localparam int SHORT_ITEMS = 150;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // Long names placed among the short random ones.
    typedef enum int {
        LONG_FULL_NAME,     // 253 characters, no trailing dot: longest legal name
        LONG_TRAILING_DOT,  // 254 characters ending in a dot: still legal
        LONG_JUST_OVER,     // 254 characters, no trailing dot: one byte too long
        LONG_ESCAPED_FULL,  // fills the store exactly, mostly backslashes: legal
        LONG_OVERRUN,       // 257 characters: overruns the store
        LONG_NOISE,         // 300 random characters
        LONG_KINDS
    } long_kind_e;

    typedef struct packed {
        logic [7:0]  ch;
        logic        fin;
        logic [15:0] qid;
        logic        rd;
        logic [15:0] qtype;
        logic [15:0] qclass;
    } name_word_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic [8:0]  length;
        logic        err;
    } msg_word_t;

    logic        i_clk               = 1'b0;
    logic        i_rst_n             = 1'b0;
    logic        i_valid             = 1'b0;
    logic        o_stall;
    logic [7:0]  i_name_char         = '0;
    logic        i_final_char        = 1'b0;
    logic [15:0] i_query_id          = '0;
    logic        i_recursion_desired = 1'b0;
    logic [15:0] i_query_type        = '0;
    logic [15:0] i_query_class       = '0;
    logic        o_valid;
    logic        i_stall             = 1'b0;
    logic [63:0] o_packet_word;
    logic [3:0]  o_bytes_valid;
    logic        o_last_word;
    logic [8:0]  o_message_length;
    logic        o_name_error;

    dns_query_packet_builder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_name_char         (i_name_char),
        .i_final_char        (i_final_char),
        .i_query_id          (i_query_id),
        .i_recursion_desired (i_recursion_desired),
        .i_query_type        (i_query_type),
        .i_query_class       (i_query_class),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_packet_word       (o_packet_word),
        .o_bytes_valid       (o_bytes_valid),
        .o_last_word         (o_last_word),
        .o_message_length    (o_message_length),
        .o_name_error        (o_name_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stimulus: character words waiting to be driven.
    name_word_t  char_words[$];
    logic [7:0]  name_buf[$];
    int          name_char_total;   // nonzero characters of the last committed name

    // Predictor state: its own copy of the character store and counters.
    logic [7:0]  name_store [STORE_DEPTH];
    int          stored_chars;
    int          counted_bytes;
    bit          name_overrun;
    logic [7:0]  msg_bytes [MSG_MAX];
    int          msg_pos;
    msg_word_t   expected_words[$];

    int          errors;
    int          cycle_no;
    logic        char_taken = 1'b0;
    name_word_t  next_word;
    bit          noisy;
    msg_word_t   got_word;
    msg_word_t   want_word;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void put_msg_byte(input logic [7:0] b);
        if (msg_pos < MSG_MAX) begin
            msg_bytes[msg_pos] = b;
        end
        msg_pos++;
    endfunction

    // Absorb one accepted character word; on the final one, queue the whole
    // message (or the lone error word) that the block should send.
    task automatic encode_query(input name_word_t w);
        int        enc_len;
        int        len_pos;
        int        lab;
        int        i;
        int        k;
        int        b;
        int        nwords;
        int        nvalid;
        logic [63:0] packed_bytes;
        msg_word_t mw;

        if (w.ch != CHAR_NUL) begin
            if (stored_chars < STORE_DEPTH) begin
                name_store[stored_chars] = w.ch;
                stored_chars++;
            end else begin
                name_overrun = 1'b1;
            end
            if (w.ch != CHAR_BSL && counted_bytes < int'(COUNT_SAT)) begin
                counted_bytes++;
            end
        end
        if (!w.fin) begin
            return;
        end

        // Encoded name: counted characters, a closing zero, and one more
        // length byte unless the name already ends in a dot.
        enc_len = counted_bytes + 1;
        if (stored_chars == 0 || name_store[stored_chars - 1] != CHAR_DOT) begin
            enc_len++;
        end

        if (name_overrun || enc_len > NAME_LIMIT) begin
            mw = '{data: '0, nbytes: '0, last: 1'b1, length: '0, err: 1'b1};
            expected_words.push_back(mw);
        end else begin
            for (i = 0; i < MSG_MAX; i++) begin
                msg_bytes[i] = 8'h00;
            end
            msg_bytes[0] = w.qid[15:8];
            msg_bytes[1] = w.qid[7:0];
            msg_bytes[2] = {7'b0, w.rd};
            msg_bytes[5] = 8'h01;
            msg_pos = HEADER_BYTES;

            // A lone dot or an empty name is the root: a single zero byte.
            if (stored_chars == 0 || (stored_chars == 1 && name_store[0] == CHAR_DOT)) begin
                put_msg_byte(8'h00);
            end else begin
                i = 0;
                do begin
                    len_pos = msg_pos;
                    lab = 0;
                    put_msg_byte(8'h00);
                    while (i < stored_chars && name_store[i] != CHAR_DOT) begin
                        if (name_store[i] != CHAR_BSL) begin
                            put_msg_byte(name_store[i]);
                            lab++;
                        end
                        i++;
                    end
                    if (len_pos < MSG_MAX) begin
                        msg_bytes[len_pos] = 8'(lab);
                    end
                    if (i < stored_chars) begin
                        i++;
                    end
                end while (i < stored_chars);
                put_msg_byte(8'h00);
            end
            put_msg_byte(w.qtype[15:8]);
            put_msg_byte(w.qtype[7:0]);
            put_msg_byte(w.qclass[15:8]);
            put_msg_byte(w.qclass[7:0]);
            if (msg_pos > MSG_MAX - 8) begin
                msg_pos = MSG_MAX - 8;
            end

            // Pack eight bytes per word, first byte on top, zero past the end.
            nwords = (msg_pos + 7) / 8;
            for (k = 0; k < nwords; k++) begin
                nvalid = msg_pos - k * 8;
                if (nvalid > 8) begin
                    nvalid = 8;
                end
                packed_bytes = '0;
                for (b = 0; b < 8; b++) begin
                    packed_bytes = {packed_bytes[55:0],
                                    (b < nvalid) ? msg_bytes[k * 8 + b] : 8'h00};
                end
                mw.data   = packed_bytes;
                mw.nbytes = 4'(nvalid);
                mw.last   = (k + 1 == nwords);
                mw.length = (k + 1 == nwords) ? 9'(msg_pos) : 9'd0;
                mw.err    = 1'b0;
                expected_words.push_back(mw);
            end
        end

        // Every final character starts a fresh name.
        stored_chars  = 0;
        counted_bytes = 0;
        name_overrun  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            name_buf.push_back(s[i]);
        end
    endtask

    task automatic add_label(input int n);
        string alnum;
        int    i;
        alnum = "abcdefghijklmnopqrstuvwxyz0123456789-";
        for (i = 0; i < n; i++) begin
            name_buf.push_back(alnum[$urandom_range(0, alnum.len() - 1)]);
        end
    endtask

    // Turn the buffered name into character words, final flag on the last;
    // an empty buffer becomes one zero character carrying the final flag.
    task automatic commit_name(input logic [15:0] qid, input logic rd,
                               input logic [15:0] qtype, input logic [15:0] qclass);
        name_word_t w;
        int         i;
        if (name_buf.size() == 0) begin
            name_buf.push_back(CHAR_NUL);
        end
        name_char_total = 0;
        for (i = 0; i < name_buf.size(); i++) begin
            w.ch     = name_buf[i];
            w.fin    = (i == name_buf.size() - 1);
            w.qid    = qid;
            w.rd     = rd;
            w.qtype  = qtype;
            w.qclass = qclass;
            char_words.push_back(w);
            if (name_buf[i] != CHAR_NUL) begin
                name_char_total++;
            end
        end
        name_buf.delete();
    endtask

    task automatic commit_random_header();
        commit_name(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Letters with a dot now and then; escaped_share of every eight
    // characters become backslashes; the last one is forced per end_dot.
    task automatic add_long_text(input int total, input bit end_dot, input int escaped_share);
        string letters;
        int    i;
        letters = "abcdefghijklmnopqrstuvwxyz";
        for (i = 0; i < total - 1; i++) begin
            if (i % 8 < escaped_share) begin
                name_buf.push_back(CHAR_BSL);
            end else if (i > 0 && $urandom_range(0, 11) == 0) begin
                name_buf.push_back(CHAR_DOT);
            end else begin
                name_buf.push_back(letters[$urandom_range(0, 25)]);
            end
        end
        name_buf.push_back(end_dot ? CHAR_DOT : letters[$urandom_range(0, 25)]);
    endtask

    task automatic queue_long_name(input long_kind_e kind);
        int i;
        case (kind)
            LONG_FULL_NAME:    add_long_text(253, 1'b0, 0);
            LONG_TRAILING_DOT: add_long_text(254, 1'b1, 0);
            LONG_JUST_OVER:    add_long_text(254, 1'b0, 0);
            LONG_ESCAPED_FULL: add_long_text(STORE_DEPTH, 1'b0, 5);
            LONG_OVERRUN:      add_long_text(STORE_DEPTH + 1, 1'b0, 0);
            default: begin
                for (i = 0; i < 300; i++) begin
                    name_buf.push_back(8'($urandom_range(1, 255)));
                end
            end
        endcase
        commit_random_header();
    endtask

    // ------------------------------------------------------------------
    // Driver: present one character word at a time, change at the falling
    // edge, hold it until the block takes it.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        cycle_no = cycle_no + 1;
        noisy = (cycle_no < QUIET_FROM) || (cycle_no >= QUIET_TO);
        if (i_rst_n) begin
            // Stall the output side now and then outside the quiet window, independent of input.
            i_stall <= noisy && ($urandom_range(0, 99) < IDLE_PCT);
            // Advance only once the held word is gone.
            if (!i_valid || char_taken) begin
                if (char_words.size() != 0 && !(noisy && $urandom_range(0, 99) < IDLE_PCT)) begin
                    next_word = char_words.pop_front();
                    i_valid             <= 1'b1;
                    i_name_char         <= next_word.ch;
                    i_final_char        <= next_word.fin;
                    i_query_id          <= next_word.qid;
                    i_recursion_desired <= next_word.rd;
                    i_query_type        <= next_word.qtype;
                    i_query_class       <= next_word.qclass;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge. Predict on every accepted input
    // word; check every accepted output word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            encode_query('{ch: i_name_char, fin: i_final_char, qid: i_query_id,
                           rd: i_recursion_desired, qtype: i_query_type,
                           qclass: i_query_class});
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got_word = '{data: o_packet_word, nbytes: o_bytes_valid, last: o_last_word,
                         length: o_message_length, err: o_name_error};
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected word: data=%h bytes=%0d last=%b len=%0d err=%b",
                             got_word.data, got_word.nbytes, got_word.last,
                             got_word.length, got_word.err);
                end
            end else begin
                want_word = expected_words.pop_front();
                if (got_word !== want_word) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected data=%h bytes=%0d last=%b len=%0d err=%b",
                                 want_word.data, want_word.nbytes, want_word.last,
                                 want_word.length, want_word.err);
                        $display("          actual   data=%h bytes=%0d last=%b len=%0d err=%b",
                                 got_word.data, got_word.nbytes, got_word.last,
                                 got_word.length, got_word.err);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int short_items;
        int long_next;
        int r;
        int i;
        int n;

        errors        = 0;
        cycle_no      = 0;
        stored_chars  = 0;
        counted_bytes = 0;
        name_overrun  = 1'b0;

        // Directed names: root, empty, field extremes, empty labels,
        // dropped backslashes and skipped zero characters.
        add_text(".");
        commit_name(16'h0000, 1'b0, 16'h0000, 16'h0000);
        commit_name(16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        add_text("ab.cd");
        commit_name(16'h1234, 1'b1, 16'h0001, 16'h0001);
        add_text(".a");
        commit_name(16'h8001, 1'b0, 16'h001C, 16'h00FF);
        add_text("a..b");
        commit_name(16'h00FF, 1'b1, 16'hFF00, 16'h8000);
        add_text("a\\.b");
        commit_name(16'h7FFF, 1'b0, 16'h0010, 16'h0003);
        name_buf.push_back("a");
        name_buf.push_back(CHAR_NUL);
        name_buf.push_back("b");
        name_buf.push_back(CHAR_NUL);
        commit_name(16'hA5A5, 1'b1, 16'h5A5A, 16'hA5A5);
        add_text("x.");
        commit_name(16'h5A5A, 1'b0, 16'h0002, 16'h0004);
        name_buf.push_back(8'h01);
        name_buf.push_back(8'hFF);
        commit_name(16'h0001, 1'b1, 16'h00FF, 16'hFF01);
        name_buf.push_back(CHAR_BSL);
        commit_name(16'hFFFE, 1'b0, 16'hFFFE, 16'h0001);

        // Random names: mostly well-formed, some noise, some broken; the
        // long names are dropped in at random places, any left over at the end.
        short_items = 0;
        long_next   = 0;
        while (short_items < SHORT_ITEMS) begin
            if (long_next < LONG_KINDS && $urandom_range(0, 5) == 0) begin
                queue_long_name(long_kind_e'(long_next));
                long_next++;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    if (i > 0) begin
                        name_buf.push_back(CHAR_DOT);
                    end
                    add_label($urandom_range(1, 8));
                end
                if ($urandom_range(0, 3) == 0) begin
                    name_buf.push_back(CHAR_DOT);
                end
            end else if (r < 85) begin
                n = $urandom_range(1, 12);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 19))
                        0:       name_buf.push_back(CHAR_NUL);
                        1:       name_buf.push_back(CHAR_DOT);
                        2:       name_buf.push_back(CHAR_BSL);
                        default: name_buf.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
            end else begin
                n = $urandom_range(1, 10);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0:       name_buf.push_back(CHAR_DOT);
                        1:       name_buf.push_back(CHAR_BSL);
                        default: add_label(1);
                    endcase
                end
            end
            commit_random_header();
            short_items += name_char_total;
        end
        while (long_next < LONG_KINDS) begin
            queue_long_name(long_kind_e'(long_next));
            long_next++;
        end

        // Hold reset, then release it at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words driven and taken, every expected word seen.
        while (char_words.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
